>>> rtl/core/jbsp_pkg.sv
// shared types and constants for the json byte stream parser
`timescale 1ns / 1ps
package jbsp_pkg;

  localparam int LEVEL_W = 6;
  localparam int EVQ_DEPTH = 4;

  // event codes
  localparam logic [4:0] EV_OBJ_START = 5'd0;
  localparam logic [4:0] EV_OBJ_END   = 5'd1;
  localparam logic [4:0] EV_ARR_START = 5'd2;
  localparam logic [4:0] EV_ARR_END   = 5'd3;
  localparam logic [4:0] EV_KEY_BYTE  = 5'd4;
  localparam logic [4:0] EV_KEY_END   = 5'd5;
  localparam logic [4:0] EV_STR_BYTE  = 5'd6;
  localparam logic [4:0] EV_STR_END   = 5'd7;
  localparam logic [4:0] EV_NUM_BYTE  = 5'd8;
  localparam logic [4:0] EV_INT_END   = 5'd9;
  localparam logic [4:0] EV_FRAC_END  = 5'd10;
  localparam logic [4:0] EV_TRUE      = 5'd11;
  localparam logic [4:0] EV_FALSE     = 5'd12;
  localparam logic [4:0] EV_NULL      = 5'd13;
  localparam logic [4:0] EV_BAD       = 5'd14;
  localparam logic [4:0] EV_EARLY     = 5'd15;
  localparam logic [4:0] EV_DEEP      = 5'd16;

  // document characters
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_LF     = 8'h0a;

  typedef struct packed {
    logic [4:0]         kind;
    logic [7:0]         data;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } jbsp_event_t;

endpackage

>>> rtl/core/jbsp_step.sv
// parser state and per-byte event logic
`timescale 1ns / 1ps
module jbsp_step import jbsp_pkg::*; #(
  parameter int MAX_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  cur_byte,
  input  logic        cur_end,
  output logic [1:0]  ev_cnt,
  output jbsp_event_t ev0,
  output jbsp_event_t ev1
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [4:0] {
    PH_VALUE, PH_NUM0, PH_NUM1, PH_STR, PH_STR_ESC, PH_KEY, PH_KEYSTR,
    PH_COLON, PH_OBJ_NEXT, PH_ARR_FIRST, PH_ARR_NEXT, PH_T1, PH_T2, PH_T3,
    PH_F1, PH_F2, PH_F3, PH_F4, PH_N1, PH_N2, PH_N3
  } phase_t;

  phase_t          phase, phase_next, ph_e;
  logic [DW-1:0]   depth, depth_next;
  logic            finished, finished_next;
  logic            error, error_next;
  logic [MAX_DEPTH:0] marks;   // bit 0 is the innermost container, 1 = object
  logic            push, pop, push_obj;
  logic            blank, is_dig;
  logic [DW-1:0]   depth_m1;

  function automatic logic [LEVEL_W-1:0] lvl(input logic [DW-1:0] x);
    logic [DW+LEVEL_W-1:0] t;
    t = {{LEVEL_W{1'b0}}, x};
    return t[LEVEL_W-1:0];
  endfunction

  function automatic jbsp_event_t mk(input logic [4:0] k, input logic [7:0] b,
                                     input logic [LEVEL_W-1:0] l);
    jbsp_event_t e;
    e.kind = k;
    e.data = b;
    e.level = l;
    e.last = 1'b0;
    return e;
  endfunction

  always_comb begin
    phase_next = phase;
    depth_next = depth;
    finished_next = finished;
    error_next = error;
    push = 1'b0;
    pop = 1'b0;
    push_obj = 1'b0;
    ev_cnt = 2'd0;
    ev0 = mk(EV_BAD, 8'd0, '0);
    ev1 = mk(EV_BAD, 8'd0, '0);
    depth_m1 = depth - 1'b1;
    blank = cur_byte inside {8'h00, 8'h20, 8'h09, 8'h0d, 8'h0a};
    is_dig = cur_byte inside {[8'h30:8'h39]};
    ph_e = (phase == PH_ARR_FIRST && cur_byte != CH_RBRACK) ? PH_VALUE : phase;

    if (cur_end) begin
      if (!error && !finished) begin
        ev_cnt = 2'd1;
        if (depth == '0 && phase == PH_NUM0) ev0 = mk(EV_INT_END, 8'd0, '0);
        else if (depth == '0 && phase == PH_NUM1) ev0 = mk(EV_FRAC_END, 8'd0, '0);
        else ev0 = mk(EV_EARLY, 8'd0, lvl(depth));
      end
      phase_next = PH_VALUE;
      depth_next = '0;
      finished_next = 1'b0;
      error_next = 1'b0;
    end else if (!error && !finished && (!blank || phase == PH_STR)) begin
      ev_cnt = 2'd1;
      ev0 = mk(EV_BAD, 8'd0, lvl(depth));
      case (ph_e)
        PH_VALUE: begin
          if (cur_byte == CH_LBRACE || cur_byte == CH_LBRACK) begin
            if (depth == DW'(MAX_DEPTH)) begin
              ev0 = mk(EV_DEEP, 8'd0, lvl(depth));
              error_next = 1'b1;
            end else begin
              push = 1'b1;
              push_obj = (cur_byte == CH_LBRACE);
              depth_next = depth + 1'b1;
              ev0 = mk(push_obj ? EV_OBJ_START : EV_ARR_START, 8'd0, lvl(depth + 1'b1));
              phase_next = push_obj ? PH_KEY : PH_ARR_FIRST;
            end
          end else if (cur_byte == "t") begin
            ev_cnt = 2'd0; phase_next = PH_T1;
          end else if (cur_byte == "f") begin
            ev_cnt = 2'd0; phase_next = PH_F1;
          end else if (cur_byte == "n") begin
            ev_cnt = 2'd0; phase_next = PH_N1;
          end else if (cur_byte == CH_QUOTE) begin
            ev_cnt = 2'd0; phase_next = PH_STR;
          end else if (is_dig || cur_byte == CH_PLUS || cur_byte == CH_MINUS) begin
            ev0 = mk(EV_NUM_BYTE, cur_byte, lvl(depth));
            phase_next = PH_NUM0;
          end else begin
            error_next = 1'b1;
          end
        end
        PH_NUM0, PH_NUM1: begin
          if (is_dig || (cur_byte == CH_DOT && phase == PH_NUM0)) begin
            ev0 = mk(EV_NUM_BYTE, cur_byte, lvl(depth));
            if (cur_byte == CH_DOT) phase_next = PH_NUM1;
          end else begin
            ev0 = mk(phase == PH_NUM0 ? EV_INT_END : EV_FRAC_END, 8'd0, lvl(depth));
            if (depth == '0) begin
              finished_next = 1'b1;
            end else begin
              // terminating byte goes to the enclosing container
              ev_cnt = 2'd2;
              ev1 = mk(EV_BAD, 8'd0, lvl(depth));
              if (marks[0]) begin
                phase_next = PH_OBJ_NEXT;
                if (cur_byte == CH_RBRACE) begin
                  ev1 = mk(EV_OBJ_END, 8'd0, lvl(depth));
                end else if (cur_byte == CH_COMMA) begin
                  ev_cnt = 2'd1; phase_next = PH_KEY;
                end else begin
                  error_next = 1'b1;
                end
              end else begin
                phase_next = PH_ARR_NEXT;
                if (cur_byte == CH_RBRACK) begin
                  ev1 = mk(EV_ARR_END, 8'd0, lvl(depth));
                end else if (cur_byte == CH_COMMA) begin
                  ev_cnt = 2'd1; phase_next = PH_VALUE;
                end else begin
                  error_next = 1'b1;
                end
              end
              if ((marks[0] && cur_byte == CH_RBRACE) || (!marks[0] && cur_byte == CH_RBRACK)) begin
                pop = 1'b1;
                depth_next = depth_m1;
                if (depth_m1 == '0) finished_next = 1'b1;
                else phase_next = marks[1] ? PH_OBJ_NEXT : PH_ARR_NEXT;
              end
            end
          end
        end
        PH_STR: begin
          if (cur_byte == CH_QUOTE) begin
            ev0 = mk(EV_STR_END, 8'd0, lvl(depth));
            if (depth == '0) finished_next = 1'b1;
            else phase_next = marks[0] ? PH_OBJ_NEXT : PH_ARR_NEXT;
          end else if (cur_byte == CH_BSLASH) begin
            ev_cnt = 2'd0; phase_next = PH_STR_ESC;
          end else begin
            ev0 = mk(EV_STR_BYTE, cur_byte, lvl(depth));
          end
        end
        PH_STR_ESC: begin
          phase_next = PH_STR;
          if (cur_byte == "n") begin
            ev0 = mk(EV_STR_BYTE, CH_LF, lvl(depth));
          end else if (cur_byte == "r") begin
            ev_cnt = 2'd0;
          end else begin
            ev_cnt = 2'd2;
            ev0 = mk(EV_STR_BYTE, CH_BSLASH, lvl(depth));
            ev1 = mk(EV_STR_BYTE, cur_byte, lvl(depth));
          end
        end
        PH_KEY, PH_OBJ_NEXT, PH_ARR_NEXT, PH_ARR_FIRST: begin
          if ((ph_e != PH_ARR_NEXT && ph_e != PH_ARR_FIRST && cur_byte == CH_RBRACE) ||
              ((ph_e == PH_ARR_NEXT || ph_e == PH_ARR_FIRST) && cur_byte == CH_RBRACK)) begin
            ev0 = mk((cur_byte == CH_RBRACE) ? EV_OBJ_END : EV_ARR_END, 8'd0, lvl(depth));
            if (depth == '0) begin
              finished_next = 1'b1;
            end else begin
              pop = 1'b1;
              depth_next = depth_m1;
              if (depth_m1 == '0) finished_next = 1'b1;
              else phase_next = marks[1] ? PH_OBJ_NEXT : PH_ARR_NEXT;
            end
          end else if (ph_e == PH_KEY && cur_byte == CH_QUOTE) begin
            ev_cnt = 2'd0; phase_next = PH_KEYSTR;
          end else if (ph_e == PH_OBJ_NEXT && cur_byte == CH_COMMA) begin
            ev_cnt = 2'd0; phase_next = PH_KEY;
          end else if (ph_e == PH_ARR_NEXT && cur_byte == CH_COMMA) begin
            ev_cnt = 2'd0; phase_next = PH_VALUE;
          end else begin
            error_next = 1'b1;
          end
        end
        PH_KEYSTR: begin
          if (cur_byte == CH_QUOTE) begin
            ev0 = mk(EV_KEY_END, 8'd0, lvl(depth));
            phase_next = PH_COLON;
          end else begin
            ev0 = mk(EV_KEY_BYTE, cur_byte, lvl(depth));
          end
        end
        PH_COLON, PH_T1, PH_T2, PH_F1, PH_F2, PH_F3, PH_N1, PH_N2: begin
          ev_cnt = 2'd0;
          case (ph_e)
            PH_COLON: if (cur_byte == CH_COLON) phase_next = PH_VALUE; else ev_cnt = 2'd1;
            PH_T1:    if (cur_byte == "r") phase_next = PH_T2; else ev_cnt = 2'd1;
            PH_T2:    if (cur_byte == "u") phase_next = PH_T3; else ev_cnt = 2'd1;
            PH_F1:    if (cur_byte == "a") phase_next = PH_F2; else ev_cnt = 2'd1;
            PH_F2:    if (cur_byte == "l") phase_next = PH_F3; else ev_cnt = 2'd1;
            PH_F3:    if (cur_byte == "s") phase_next = PH_F4; else ev_cnt = 2'd1;
            PH_N1:    if (cur_byte == "u") phase_next = PH_N2; else ev_cnt = 2'd1;
            PH_N2:    if (cur_byte == "l") phase_next = PH_N3; else ev_cnt = 2'd1;
            default:  ev_cnt = 2'd1;
          endcase
          if (ev_cnt != 2'd0) error_next = 1'b1;
        end
        PH_T3, PH_F4, PH_N3: begin
          if ((ph_e == PH_T3 && cur_byte == "e") || (ph_e == PH_F4 && cur_byte == "e") ||
              (ph_e == PH_N3 && cur_byte == "l")) begin
            ev0 = mk((ph_e == PH_T3) ? EV_TRUE : (ph_e == PH_F4) ? EV_FALSE : EV_NULL,
                     8'd0, lvl(depth));
            if (depth == '0) finished_next = 1'b1;
            else phase_next = marks[0] ? PH_OBJ_NEXT : PH_ARR_NEXT;
          end else begin
            error_next = 1'b1;
          end
        end
        default: error_next = 1'b1;
      endcase
    end

    if (ev_cnt == 2'd1) ev0.last = 1'b1;
    if (ev_cnt == 2'd2) ev1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_VALUE;
      depth <= '0;
      finished <= 1'b0;
      error <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      depth <= depth_next;
      finished <= finished_next;
      error <= error_next;
    end
  end

  // container marks as a shift stack, no reset needed
  always_ff @(posedge clk) begin
    if (fire && push) begin
      marks <= {marks[MAX_DEPTH-1:0], push_obj};
    end else if (fire && pop) begin
      marks <= {marks[MAX_DEPTH], marks[MAX_DEPTH:1]};
    end
  end

endmodule

>>> rtl/core/jbsp_evq.sv
// small event queue taking up to two events a cycle
`timescale 1ns / 1ps
module jbsp_evq import jbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  wr_cnt,
  input  jbsp_event_t wr0,
  input  jbsp_event_t wr1,
  input  logic        rd,
  output jbsp_event_t head,
  output logic        not_empty,
  output logic        room2
);

  localparam int AW = $clog2(EVQ_DEPTH);

  jbsp_event_t   q [EVQ_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign head = q[rp];
  assign not_empty = (cnt != '0);
  assign room2 = (cnt <= (AW+1)'(EVQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr_cnt != 2'd0) q[wp] <= wr0;
      if (wr_cnt == 2'd2) q[wp + 1'b1] <= wr1;
      wp <= wp + AW'(wr_cnt);
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr_cnt) - (AW+1)'(rd);
    end
  end

endmodule

>>> rtl/core/json_byte_stream_parser_unit.sv
// top level of the json byte stream parser
// an accepted byte is registered, then its events are queued
// throughput: one byte per cycle while the queue has room for two events;
//   the queue drains one event per cycle while out_stall is low
// reset: synchronous active-high rst clears the parse state, input register
//   and event queue; the container mark stack holds no reset
`timescale 1ns / 1ps
module json_byte_stream_parser_unit import jbsp_pkg::*; #(
  parameter int MAX_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  // input beats
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_end,
  // event beats
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] event_kind,
  output logic [7:0] event_byte,
  output logic [5:0] nest_level,
  output logic       run_last
);

  // input register
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_end;

  logic        room2, fire, q_ne;
  logic [1:0]  ev_cnt;
  jbsp_event_t ev0, ev1, head;

  // the held byte is parsed once the queue can take two events
  assign fire = s_valid && room2;
  assign in_stall = s_valid && !room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) s_valid <= 1'b1;
      else if (fire) s_valid <= 1'b0;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_byte <= in_byte;
      s_end <= is_end;
    end
  end

  jbsp_step #(.MAX_DEPTH(MAX_DEPTH)) u_step (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .cur_byte(s_byte),
    .cur_end(s_end),
    .ev_cnt(ev_cnt),
    .ev0(ev0),
    .ev1(ev1)
  );

  jbsp_evq u_evq (
    .clk(clk),
    .rst(rst),
    .wr_cnt(fire ? ev_cnt : 2'd0),
    .wr0(ev0),
    .wr1(ev1),
    .rd(out_valid && !out_stall),
    .head(head),
    .not_empty(q_ne),
    .room2(room2)
  );

  // event beat straight from the queue head
  assign out_valid = q_ne;
  assign event_kind = head.kind;
  assign event_byte = head.data;
  assign nest_level = head.level;
  assign run_last = head.last;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s_valid) else $error("stall without a held byte");
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !room2 |-> out_valid) else $error("queue short of room but empty");
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s_valid) else $error("state left after reset");
`endif

endmodule

>>> tb/json_byte_stream_parser_unit_chk.sv
// event checker for the json byte stream parser: predicts events per byte and compares
`timescale 1ns / 1ps
module json_byte_stream_parser_unit_chk import jbsp_pkg::*; #(
  parameter int MAX_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [4:0] event_kind,
  input  logic [7:0] event_byte,
  input  logic [5:0] nest_level,
  input  logic       run_last,
  output int         fail_count,
  output int         pending_events
);

  typedef enum logic [4:0] {
    P_VALUE, P_NUM_INT, P_NUM_FRAC, P_STR, P_STR_ESC, P_KEY, P_KEY_STR, P_COLON,
    P_OBJ_NEXT, P_ARR_FIRST, P_ARR_NEXT, P_T1, P_T2, P_T3, P_F1, P_F2, P_F3, P_F4,
    P_N1, P_N2, P_N3
  } phase_t;

  phase_t          phase;
  logic            is_obj_mark [MAX_DEPTH];
  int unsigned     depth;
  logic            done_flag;
  logic            err_flag;
  jbsp_event_t     step_events[$];
  jbsp_event_t     expected_events[$];

  function automatic bit blank_byte(logic [7:0] c);
    return c == 8'h00 || c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic bit digit_byte(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  task automatic push_event(logic [4:0] k, logic [7:0] d, int unsigned lvl);
    jbsp_event_t e;
    if (step_events.size() < 2) begin
      e.kind  = k;
      e.data  = d;
      e.level = lvl[5:0];
      e.last  = 1'b0;
      step_events.push_back(e);
    end
  endtask

  task automatic flag_bad();
    push_event(EV_BAD, 8'h00, depth);
    err_flag = 1'b1;
  endtask

  task automatic close_value();
    if (depth == 0) done_flag = 1'b1;
    else phase = is_obj_mark[depth - 1] ? P_OBJ_NEXT : P_ARR_NEXT;
  endtask

  task automatic open_level(bit obj);
    if (depth >= MAX_DEPTH) begin
      push_event(EV_DEEP, 8'h00, depth);
      err_flag = 1'b1;
    end else begin
      is_obj_mark[depth] = obj;
      depth++;
      push_event(obj ? EV_OBJ_START : EV_ARR_START, 8'h00, depth);
      phase = obj ? P_KEY : P_ARR_FIRST;
    end
  endtask

  task automatic close_level(bit obj);
    push_event(obj ? EV_OBJ_END : EV_ARR_END, 8'h00, depth);
    if (depth > 0) depth--;
    close_value();
  endtask

  task automatic want_byte(logic [7:0] c, logic [7:0] want, phase_t nxt);
    if (c == want) phase = nxt;
    else flag_bad();
  endtask

  task automatic literal_end(logic [7:0] c, logic [7:0] want, logic [4:0] k);
    if (c == want) begin
      push_event(k, 8'h00, depth);
      close_value();
    end else begin
      flag_bad();
    end
  endtask

  task automatic parse_byte(logic [7:0] c);
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      // first slot of an array falls through to value handling unless it closes the array
      if (phase == P_ARR_FIRST) begin
        if (c == CH_RBRACK) begin
          close_level(1'b0);
          continue;
        end
        phase = P_VALUE;
      end
      case (phase)
        P_VALUE: begin
          if (c == CH_LBRACE) open_level(1'b1);
          else if (c == CH_LBRACK) open_level(1'b0);
          else if (c == "t") phase = P_T1;
          else if (c == "f") phase = P_F1;
          else if (c == "n") phase = P_N1;
          else if (c == CH_QUOTE) phase = P_STR;
          else if (c == CH_MINUS || c == CH_PLUS || digit_byte(c)) begin
            push_event(EV_NUM_BYTE, c, depth);
            phase = P_NUM_INT;
          end else flag_bad();
        end
        P_NUM_INT, P_NUM_FRAC: begin
          if (digit_byte(c) || (c == CH_DOT && phase == P_NUM_INT)) begin
            push_event(EV_NUM_BYTE, c, depth);
            if (c == CH_DOT) phase = P_NUM_FRAC;
          end else begin
            // number closes, terminator goes to the enclosing container
            push_event(phase == P_NUM_INT ? EV_INT_END : EV_FRAC_END, 8'h00, depth);
            close_value();
            if (!done_flag) again = 1'b1;
          end
        end
        P_STR: begin
          if (c == CH_QUOTE) begin
            push_event(EV_STR_END, 8'h00, depth);
            close_value();
          end else if (c == CH_BSLASH) phase = P_STR_ESC;
          else push_event(EV_STR_BYTE, c, depth);
        end
        P_STR_ESC: begin
          if (c == "n") push_event(EV_STR_BYTE, CH_LF, depth);
          else if (c != "r") begin
            push_event(EV_STR_BYTE, CH_BSLASH, depth);
            push_event(EV_STR_BYTE, c, depth);
          end
          phase = P_STR;
        end
        P_KEY: begin
          if (c == CH_QUOTE) phase = P_KEY_STR;
          else if (c == CH_RBRACE) close_level(1'b1);
          else flag_bad();
        end
        P_KEY_STR: begin
          if (c == CH_QUOTE) begin
            push_event(EV_KEY_END, 8'h00, depth);
            phase = P_COLON;
          end else push_event(EV_KEY_BYTE, c, depth);
        end
        P_COLON: want_byte(c, CH_COLON, P_VALUE);
        P_OBJ_NEXT: begin
          if (c == CH_RBRACE) close_level(1'b1);
          else if (c == CH_COMMA) phase = P_KEY;
          else flag_bad();
        end
        P_ARR_NEXT: begin
          if (c == CH_RBRACK) close_level(1'b0);
          else if (c == CH_COMMA) phase = P_VALUE;
          else flag_bad();
        end
        P_T1: want_byte(c, "r", P_T2);
        P_T2: want_byte(c, "u", P_T3);
        P_T3: literal_end(c, "e", EV_TRUE);
        P_F1: want_byte(c, "a", P_F2);
        P_F2: want_byte(c, "l", P_F3);
        P_F3: want_byte(c, "s", P_F4);
        P_F4: literal_end(c, "e", EV_FALSE);
        P_N1: want_byte(c, "u", P_N2);
        P_N2: want_byte(c, "l", P_N3);
        P_N3: literal_end(c, "l", EV_NULL);
        default: flag_bad();
      endcase
    end
  endtask

  task automatic restart_parser();
    phase = P_VALUE;
    depth = 0;
    done_flag = 1'b0;
    err_flag = 1'b0;
  endtask

  task automatic predict_beat(logic [7:0] c, logic fin);
    step_events.delete();
    if (fin) begin
      if (!err_flag && !done_flag) begin
        if (depth == 0 && (phase == P_NUM_INT || phase == P_NUM_FRAC))
          push_event(phase == P_NUM_INT ? EV_INT_END : EV_FRAC_END, 8'h00, 0);
        else
          push_event(EV_EARLY, 8'h00, depth);
      end
      restart_parser();
    end else if (!err_flag && !done_flag) begin
      if (!blank_byte(c) || phase == P_STR) parse_byte(c);
    end
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: event mismatch on %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    restart_parser();
  end

  assign pending_events = expected_events.size();

  always @(posedge clk) begin
    jbsp_event_t w;
    if (rst) begin
      restart_parser();
      expected_events.delete();
    end else begin
      // predict first so an event can never reach the compare before its prediction
      if (in_valid && !in_stall) predict_beat(in_byte, is_end);
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          report("unexpected beat, kind", 32'(event_kind), 32'd0);
        end else begin
          w = expected_events.pop_front();
          if (event_kind !== w.kind) report("kind", event_kind, w.kind);
          if (event_byte !== w.data) report("byte", event_byte, w.data);
          if (nest_level !== w.level) report("level", nest_level, w.level);
          if (run_last !== w.last) report("last", run_last, w.last);
        end
      end
    end
  end

endmodule

>>> tb/json_byte_stream_parser_unit_tb.sv
// testbench top for the json byte stream parser: stimulus, stall and verdict
`timescale 1ns / 1ps
module json_byte_stream_parser_unit_tb import jbsp_pkg::*;;

  localparam int WATCHDOG_LIMIT = 5000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       is_end;
  logic       out_valid;
  logic       out_stall;
  logic [4:0] event_kind;
  logic [7:0] event_byte;
  logic [5:0] nest_level;
  logic       run_last;
  int         fail_count;
  int         pending_events;
  int         idle_cycles;
  bit         stim_done;

  // document bytes waiting to be sent: bit 8 marks the end marker
  logic [8:0] doc_bytes[$];

  json_byte_stream_parser_unit #(.MAX_DEPTH(32)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .is_end    (is_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_kind(event_kind),
    .event_byte(event_byte),
    .nest_level(nest_level),
    .run_last  (run_last)
  );

  json_byte_stream_parser_unit_chk #(.MAX_DEPTH(32)) i_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .is_end        (is_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .event_byte    (event_byte),
    .nest_level    (nest_level),
    .run_last      (run_last),
    .fail_count    (fail_count),
    .pending_events(pending_events)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---- document builders ----
  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back({1'b0, s[i]});
  endtask

  task automatic put_end();
    doc_bytes.push_back(9'h100);
  endtask

  // whitespace sprinkled between tokens, a blank kind picked at random
  task automatic put_blank();
    logic [7:0] blanks[5];
    blanks = '{8'h00, 8'h20, 8'h09, 8'h0d, 8'h0a};
    if ($urandom_range(0, 3) == 0) doc_bytes.push_back({1'b0, blanks[$urandom_range(0, 4)]});
  endtask

  task automatic put_number();
    int n;
    n = $urandom_range(1, 4);
    case ($urandom_range(0, 3))
      0: put_text("-");
      1: put_text("+");
      default: ;
    endcase
    for (int i = 0; i < n; i++) doc_bytes.push_back({1'b0, 8'h30 + 8'($urandom_range(0, 9))});
    if ($urandom_range(0, 1)) begin
      put_text(".");
      for (int i = 0; i < n; i++) doc_bytes.push_back({1'b0, 8'h30 + 8'($urandom_range(0, 9))});
    end
  endtask

  // string body: any byte but an unescaped quote, with escapes in value strings
  task automatic put_string(bit as_key);
    int n;
    logic [7:0] c;
    n = $urandom_range(0, 5);
    put_text("\"");
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_QUOTE) c = 8'h41;
      if (!as_key && c == CH_BSLASH) begin
        doc_bytes.push_back({1'b0, c});
        case ($urandom_range(0, 3))
          0: c = "n";
          1: c = "r";
          default: c = 8'($urandom_range(0, 255));
        endcase
      end
      doc_bytes.push_back({1'b0, c});
    end
    put_text("\"");
  endtask

  task automatic put_value(int lvl);
    int n;
    put_blank();
    case ($urandom_range(0, (lvl < 4) ? 7 : 5))
      0: put_text("true");
      1: put_text("false");
      2: put_text("null");
      3: put_number();
      4, 5: put_string(1'b0);
      6: begin
        n = $urandom_range(0, 3);
        put_text("[");
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_text(",");
          put_value(lvl + 1);
        end
        put_blank();
        put_text("]");
      end
      default: begin
        n = $urandom_range(0, 3);
        put_text("{");
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_text(",");
          put_blank();
          put_string(1'b1);
          put_blank();
          put_text(":");
          put_value(lvl + 1);
        end
        if (n > 0 && $urandom_range(0, 4) == 0) put_text(",");
        put_text("}");
      end
    endcase
    put_blank();
  endtask

  // ---- directed documents ----
  task automatic build_directed();
    put_text("{\"k\xff\":[true,false,null,-1.5,+7,\"a\\nb\\r\\x\"],\"e\":{},}");
    put_end();
    put_text("[]");
    put_end();
    put_text("12.");
    put_end();
    put_text("0");
    put_end();
    put_text("\" \t\x00\"x");
    put_end();
    put_text("tx");
    put_end();
    put_text("[1 2");
    put_end();
    put_end();
    for (int i = 0; i < 33; i++) put_text("[");
    put_end();
    doc_bytes.push_back({1'b0, 8'hff});
    put_end();
    doc_bytes.push_back({1'b1, 8'hff});
  endtask

  // ---- random documents: mostly well formed, some broken or cut short ----
  task automatic build_random();
    int start_size;
    logic [7:0] c;
    start_size = doc_bytes.size();
    while (doc_bytes.size() - start_size < 1200) begin
      case ($urandom_range(0, 9))
        0: begin
          for (int i = 0; i < $urandom_range(1, 8); i++)
            doc_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
        1: begin
          put_value(0);
          if (doc_bytes.size() > 0) void'(doc_bytes.pop_back());
        end
        default: put_value(0);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        c = 8'($urandom_range(0, 255));
        doc_bytes.push_back({1'b0, c});
      end
      doc_bytes.push_back({1'b1, 8'($urandom_range(0, 255))});
    end
  endtask

  // ---- input side ----
  initial begin
    int gap;
    logic [8:0] item;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    is_end = 1'b0;
    stim_done = 1'b0;
    build_directed();
    build_random();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (doc_bytes.size() > 0) begin
      item = doc_bytes.pop_front();
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte <= item[7:0];
      is_end <= item[8];
      // hold the beat until it is taken
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // ---- event side stall: bursts of stall, then runs with none ----
  initial begin
    int hold;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      hold = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // ---- watchdog on cycles with no accepted beat, active for the whole run ----
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("json_byte_stream_parser_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    wait (stim_done);
    // let the checker take in the last beat before looking at its backlog
    repeat (2) @(posedge clk);
    while (pending_events > 0) @(posedge clk);
    // drain window for any stray late event
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_events == 0) begin
      $display("json_byte_stream_parser_unit_tb: PASS");
    end else begin
      $display("json_byte_stream_parser_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
